/* hdl/mopl_pkg.sv */
// ----------------------------------------------------------------------------
// mopl_pkg
// Item types, status codes and register map of the multichannel one-pole
// low-pass filter.
// ----------------------------------------------------------------------------
package mopl_pkg;

  localparam int SAMPLE_W = 25;
  localparam int CHAN_REG_W = 5;
  localparam int COEFF_REG_W = 16;

  localparam logic signed [SAMPLE_W-1:0] ONE_Q23 = 25'sd8388608;
  localparam logic signed [SAMPLE_W-1:0] NEG_ONE_Q23 = -25'sd8388608;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_RANGE      = 2'd1;
  localparam logic [1:0] STATUS_MISALIGNED = 2'd2;
  localparam logic [1:0] STATUS_ABORTED    = 2'd3;

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic REG_COEFF    = 1'b1;

  localparam logic [CHAN_REG_W-1:0] CHANNELS_RESET = 5'd1;
  localparam logic [COEFF_REG_W-1:0] COEFF_RESET = 16'd32768;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clear_hist;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic [1:0]                 status;
    logic                       last_out;
  } out_item_t;

endpackage

/* hdl/multichannel_one_pole_low_pass_top.sv */
// ----------------------------------------------------------------------------
// multichannel_one_pole_low_pass_top
// Interleaved multichannel one-pole low-pass filter with per-batch commit
// and rollback of the channel histories.
// ----------------------------------------------------------------------------
//  channel   | signals                        | payload
//  ----------+--------------------------------+----------------------------
//  samples   | smp_valid / smp_ready          | smp_item  (mopl_pkg::in_item_t)
//  results   | flt_valid / flt_ready          | flt_item  (mopl_pkg::out_item_t)
//  config    | psel penable pwrite paddr ...  | pwdata / prdata, 32 bits
//
// One item per cycle unless the result queue fills; results are registered.
// Histories sit in one RAM of two banks per channel; a per-channel bank bit
// and dirty bit make commit and rollback a flag update.
// Back-to-back items on one channel use a forwarding register past the RAM.
// A three-entry result queue absorbs stalls; input stalls once the queue and
// the filter stage together hold three items.
// Reset clears the per-channel flags; no clearing pass over the RAM.
// ----------------------------------------------------------------------------
module multichannel_one_pole_low_pass_top #(
  parameter int MAX_CHANNELS = 16,
  parameter int COEFF_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               smp_valid,
  output logic               smp_ready,
  input  mopl_pkg::in_item_t smp_item,
  output logic               flt_valid,
  input  logic               flt_ready,
  output mopl_pkg::out_item_t flt_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import mopl_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int ADDR_W = CH_W + 1;
  localparam int RAM_DEPTH = 2 * (2 ** CH_W);
  localparam int PROD_W = SAMPLE_W + 2 + COEFF_BITS;
  localparam logic [8:0] MAX_N = 9'(MAX_CHANNELS);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       primed;
    logic                       filter;
    logic [1:0]                 status;
    logic                       last;
  } s1_t;

  // configuration
  logic [CHAN_REG_W-1:0]  channels_in_use;
  logic [COEFF_REG_W-1:0] smoothing_coefficient;
  logic                   cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CHANNELS_RESET;
      smoothing_coefficient <= COEFF_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CHANNELS: channels_in_use <= pwdata[CHAN_REG_W-1:0];
        REG_COEFF:    smoothing_coefficient <= pwdata[COEFF_REG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHANNELS: prdata = 32'(channels_in_use);
      REG_COEFF:    prdata = 32'(smoothing_coefficient);
      default:      prdata = '0;
    endcase
  end

  // batch control state
  logic [MAX_CHANNELS-1:0] committed_primed;
  logic [MAX_CHANNELS-1:0] working_primed;
  logic [MAX_CHANNELS-1:0] dirty;
  logic [MAX_CHANNELS-1:0] bank;
  logic [CH_W-1:0]         position;
  logic                    batch_failed;
  logic                    at_batch_start;

  logic                    accept;
  logic [8:0]              cfg_n;
  logic [8:0]              n_wide;
  logic [CNT_W-1:0]        n;
  logic [CH_W-1:0]         pos_base;
  logic [CH_W-1:0]         ch;
  logic [CNT_W-1:0]        ch_plus;
  logic [CH_W-1:0]         pos_next;
  logic [MAX_CHANNELS-1:0] wp_eff;
  logic [MAX_CHANNELS-1:0] wp_next;
  logic [MAX_CHANNELS-1:0] dirty_next;
  logic                    failed_eff;
  logic                    failed_next;
  logic                    out_of_range;
  logic                    do_filter;
  logic [1:0]              status0;
  logic                    rd_bank;
  s1_t                     s1_in;

  always_comb begin
    cfg_n = 9'(channels_in_use);
    if (cfg_n == 9'd0) begin
      n_wide = 9'd1;
    end else if (cfg_n > MAX_N) begin
      n_wide = MAX_N;
    end else begin
      n_wide = cfg_n;
    end
    n = n_wide[CNT_W-1:0];

    pos_base = at_batch_start ? '0 : position;
    ch = (CNT_W'(pos_base) >= n) ? '0 : pos_base;
    ch_plus = CNT_W'(ch) + CNT_W'(1);
    pos_next = (ch_plus >= n) ? '0 : ch_plus[CH_W-1:0];

    if (at_batch_start) begin
      wp_eff = smp_item.clear_hist ? '0 : committed_primed;
    end else begin
      wp_eff = working_primed;
    end
    failed_eff = at_batch_start ? 1'b0 : batch_failed;

    out_of_range = (smp_item.sample < NEG_ONE_Q23) || (smp_item.sample > ONE_Q23);
    wp_next = wp_eff;
    dirty_next = dirty;
    do_filter = 1'b0;
    failed_next = failed_eff;
    if (failed_eff) begin
      status0 = STATUS_ABORTED;
    end else if (out_of_range) begin
      status0 = STATUS_RANGE;
      failed_next = 1'b1;
    end else begin
      status0 = STATUS_OK;
      do_filter = 1'b1;
      wp_next[ch] = 1'b1;
      dirty_next[ch] = 1'b1;
    end
    if (smp_item.last && !failed_next && pos_next != '0) begin
      status0 = STATUS_MISALIGNED;
      failed_next = 1'b1;
    end

    rd_bank = dirty[ch] ? ~bank[ch] : bank[ch];
    s1_in.x = smp_item.sample;
    s1_in.rd_addr = {rd_bank, ch};
    s1_in.wr_addr = {~bank[ch], ch};
    s1_in.primed = wp_eff[ch];
    s1_in.filter = do_filter;
    s1_in.status = status0;
    s1_in.last = smp_item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      committed_primed <= '0;
      working_primed <= '0;
      dirty <= '0;
      bank <= '0;
      position <= '0;
      batch_failed <= 1'b0;
      at_batch_start <= 1'b1;
    end else if (accept) begin
      working_primed <= wp_next;
      position <= pos_next;
      batch_failed <= failed_next;
      at_batch_start <= smp_item.last;
      if (smp_item.last) begin
        dirty <= '0;
        if (!failed_next) begin
          committed_primed <= wp_next;
          bank <= bank ^ dirty_next;
        end
      end else begin
        dirty <= dirty_next;
      end
    end
  end

  // history RAM and filter stage
  s1_t                        s1;
  logic                       s1_valid;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       ram_we;
  logic signed [SAMPLE_W-1:0] y_old;
  logic signed [SAMPLE_W-1:0] y_new;
  logic signed [SAMPLE_W:0]   diff;
  logic [39:0]                coeff_wide;
  logic [COEFF_BITS-1:0]      alpha;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   step;
  logic                       fwd_valid;
  logic [ADDR_W-1:0]          fwd_addr;
  logic signed [SAMPLE_W-1:0] fwd_data;
  out_item_t                  s1_out;

  mopl_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RAM_DEPTH)
  ) u_hist_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1.wr_addr),
    .wdata(y_new),
    .raddr(s1_in.rd_addr),
    .rdata(ram_rdata)
  );

  assign ram_we = s1_valid && s1.filter;
  assign coeff_wide = 40'(smoothing_coefficient);
  assign alpha = coeff_wide[COEFF_BITS-1:0];

  always_comb begin
    if (fwd_valid && fwd_addr == s1.rd_addr) begin
      y_old = fwd_data;
    end else begin
      y_old = $signed(ram_rdata);
    end
    diff = (SAMPLE_W + 1)'(s1.x) - (SAMPLE_W + 1)'(y_old);
    prod = PROD_W'(diff) * $signed({1'b0, alpha});
    step = (prod + (PROD_W'(1) <<< (COEFF_BITS - 1))) >>> COEFF_BITS;
    if (s1.primed) begin
      y_new = y_old + step[SAMPLE_W-1:0];
    end else begin
      y_new = s1.x;
    end
    s1_out.filtered = (s1.status == STATUS_OK) ? y_new : '0;
    s1_out.status = s1.status;
    s1_out.last_out = s1.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      fwd_valid <= ram_we;
    end
    s1 <= s1_in;
    fwd_addr <= s1.wr_addr;
    fwd_data <= y_new;
  end

  // result queue
  out_item_t  queue [3];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign flt_valid = count != 2'd0;
  assign flt_item = queue[rd_ptr];
  assign pop = flt_valid && flt_ready;
  assign smp_ready = (3'(count) + 3'(s1_valid)) <= 3'd2;
  assign accept = smp_valid && smp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + 2'(s1_valid) - 2'(pop);
    end
    if (s1_valid) begin
      queue[wr_ptr] <= s1_out;
    end
  end

endmodule

/* hdl/mopl_ram.sv */
// ----------------------------------------------------------------------------
// mopl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mopl_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
